@@ hdl/fppa_pkg.sv @@
// ----------------------------------------------------------------------------
// fppa_pkg: shared types for the fenced page pool allocator
// Holds the item kind codes, result codes, the stored page entry and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fppa_pkg;

    // Item kinds as they arrive on the input word.
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RECYCLE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Largest page count one allocate word may request.
    localparam logic [6:0] MAX_ALLOC = 7'd64;

    // Saturation value of the recycled page counter.
    localparam logic [11:0] MOVED_MAX = 12'hFFF;

    // Output field widths.
    localparam int PAGE_W   = 11;
    localparam int HEAP_W   = 4;
    localparam int OFFSET_W = 7;

    // Which result word the datapath builds.
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_PAGE,
        RES_EXHAUST,
        RES_FULL,
        RES_RECYCLE
    } res_sel_t;

    // One page as kept in the free and pending queues, already split into
    // its heap number and offset as they appear on the output.
    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [HEAP_W-1:0]   heap;
        logic [OFFSET_W-1:0] offset;
    } page_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch_in;
        logic     chunk_push;
        logic     alloc_pop;
        logic     free_commit;
        logic     batch_rd;
        logic     batch_load;
        logic     pend_rd;
        logic     recycle_push;
        logic     batch_pop;
        logic     moved_clr;
        logic     emit;
        logic     emit_last;
        res_sel_t emit_sel;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  last_in;
        logic  alloc_final;
        logic  free_empty;
        logic  pool_exhausted;
        logic  chunk_last;
        logic  pend_full;
        logic  pend_empty;
        logic  batch_full;
        logic  batch_empty;
        logic  fence_ok;
        logic  remain_zero;
        logic  out_free;
    } dp_status_t;

endpackage

@@ hdl/fppa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fppa_ctrl: sequencing controller of the page pool allocator
// Decodes each input word and steps the datapath through allocation, chunk
// refill, deferred free and fence-gated recycling, one page per step.
// ----------------------------------------------------------------------------
module fppa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fppa_pkg::dp_status_t status,
    output fppa_pkg::dp_cmd_t    cmd
);
    import fppa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_A_CHECK,
        S_A_CHUNK,
        S_A_READ,
        S_A_EMIT,
        S_F_MUL,
        S_F_COMMIT,
        S_R_CHECK,
        S_R_TEST,
        S_R_PRD,
        S_R_PWR,
        S_R_NEXT,
        S_EMIT_ONE
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    // State and the selected single result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    // A new word is taken only when the previous one is fully handled.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.emit_sel = RES_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.kind)
                    KIND_ALLOC:
                    begin
                        if (status.count_zero)
                        begin
                            res_sel_next = RES_ZERO;
                            state_next   = S_EMIT_ONE;
                        end
                        else
                        begin
                            state_next = S_A_CHECK;
                        end
                    end
                    KIND_FREE:
                    begin
                        if (status.pend_full || (status.last_in && status.batch_full))
                        begin
                            res_sel_next = RES_FULL;
                            state_next   = S_EMIT_ONE;
                        end
                        else
                        begin
                            state_next = S_F_MUL;
                        end
                    end
                    KIND_RECYCLE:
                    begin
                        cmd.moved_clr = 1'b1;
                        state_next    = S_R_CHECK;
                    end
                    KIND_NONE:
                    begin
                        res_sel_next = RES_ZERO;
                        state_next   = S_EMIT_ONE;
                    end
                endcase
            end
            S_A_CHECK:
            begin
                if (status.free_empty)
                begin
                    if (status.pool_exhausted)
                    begin
                        res_sel_next = RES_EXHAUST;
                        state_next   = S_EMIT_ONE;
                    end
                    else
                    begin
                        state_next = S_A_CHUNK;
                    end
                end
                else
                begin
                    state_next = S_A_READ;
                end
            end
            S_A_CHUNK:
            begin
                cmd.chunk_push = 1'b1;
                if (status.chunk_last)
                begin
                    state_next = S_A_READ;
                end
            end
            S_A_READ:
            begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_A_EMIT;
            end
            S_A_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = RES_PAGE;
                    cmd.emit_last = status.alloc_final;
                    state_next    = status.alloc_final ? S_IDLE : S_A_CHECK;
                end
            end
            S_F_MUL:
            begin
                state_next = S_F_COMMIT;
            end
            S_F_COMMIT:
            begin
                cmd.free_commit = 1'b1;
                res_sel_next    = RES_ZERO;
                state_next      = S_EMIT_ONE;
            end
            S_R_CHECK:
            begin
                if (status.batch_empty)
                begin
                    res_sel_next = RES_RECYCLE;
                    state_next   = S_EMIT_ONE;
                end
                else
                begin
                    cmd.batch_rd = 1'b1;
                    state_next   = S_R_TEST;
                end
            end
            S_R_TEST:
            begin
                if (status.fence_ok)
                begin
                    cmd.batch_load = 1'b1;
                    state_next     = S_R_PRD;
                end
                else
                begin
                    res_sel_next = RES_RECYCLE;
                    state_next   = S_EMIT_ONE;
                end
            end
            S_R_PRD:
            begin
                if (status.remain_zero || status.pend_empty)
                begin
                    state_next = S_R_NEXT;
                end
                else
                begin
                    cmd.pend_rd = 1'b1;
                    state_next  = S_R_PWR;
                end
            end
            S_R_PWR:
            begin
                cmd.recycle_push = 1'b1;
                state_next       = S_R_PRD;
            end
            S_R_NEXT:
            begin
                cmd.batch_pop = 1'b1;
                state_next    = S_R_CHECK;
            end
            S_EMIT_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = res_sel_reg;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/fppa_dpath.sv @@
// ----------------------------------------------------------------------------
// fppa_dpath: queues, batch store and result register of the page pool
// Holds the free and pending page queues, the batch fence and size store,
// the chunk refill counters, the page split unit and the output register.
// ----------------------------------------------------------------------------
module fppa_dpath #(
    parameter int PAGES_PER_HEAP  = 128,
    parameter int MAX_HEAPS       = 16,
    parameter int PENDING_BATCHES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fppa_pkg::dp_cmd_t      cmd,
    output fppa_pkg::dp_status_t   status,
    input  fppa_pkg::kind_t        kind,
    input  logic [6:0]             alloc_count,
    input  logic [10:0]            page_index,
    input  logic [31:0]            fence_value,
    input  logic                   batch_last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [10:0]            out_page,
    output logic [3:0]             heap_number,
    output logic [6:0]             heap_offset,
    output logic [1:0]             status_code,
    output logic [11:0]            pages_recycled,
    output logic                   last_result
);
    import fppa_pkg::*;

    localparam int POOL_PAGES = PAGES_PER_HEAP * MAX_HEAPS;
    localparam int PAW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int FW  = $clog2(POOL_PAGES + 1);
    localparam int BW  = $clog2(PENDING_BATCHES);
    localparam int BFW = $clog2(PENDING_BATCHES + 1);
    localparam int JW  = (PAGES_PER_HEAP > 1) ? $clog2(PAGES_PER_HEAP) : 1;
    localparam int CW  = $clog2(MAX_HEAPS + 1);

    // Reciprocal for splitting an 11-bit page into heap and offset.
    localparam int SHIFT = PAGE_W + $clog2(PAGES_PER_HEAP);
    localparam int RECIP = ((2 ** SHIFT) + PAGES_PER_HEAP - 1) / PAGES_PER_HEAP;
    localparam int RW    = 13;
    localparam int MW    = PAGE_W + RW;

    // Memories.
    page_entry_t free_mem [POOL_PAGES];
    page_entry_t pend_mem [POOL_PAGES];
    logic [31:0] fence_mem [PENDING_BATCHES];
    logic [FW-1:0] size_mem [PENDING_BATCHES];

    // Latched input word.
    kind_t       kind_reg;
    logic [6:0]  count_reg;
    logic [10:0] page_in_reg;
    logic [31:0] fence_in_reg;
    logic        last_in_reg;

    // Queue and batch control.
    logic [PAW-1:0] free_head_reg, free_tail_reg;
    logic [FW-1:0]  free_fill_reg;
    logic [PAW-1:0] pend_head_reg, pend_tail_reg;
    logic [FW-1:0]  pend_count_reg;
    logic [BW-1:0]  batch_head_reg, batch_tail_reg;
    logic [BFW-1:0] batch_fill_reg;
    logic [FW-1:0]  open_size_reg;
    logic [FW-1:0]  remain_reg;
    logic [CW-1:0]  chunks_reg;
    logic [JW-1:0]  chunk_off_reg;
    logic [10:0]    chunk_page_reg;
    logic [6:0]     count_left_reg;
    logic [11:0]    moved_reg;
    logic           out_valid_reg;

    // Read data and product registers.
    page_entry_t    free_rd_reg;
    page_entry_t    pend_rd_reg;
    logic [31:0]    fence_rd_reg;
    logic [FW-1:0]  size_rd_reg;
    logic [MW-1:0]  mul_reg;

    // Output payload registers and their next values.
    logic [10:0] out_page_reg;
    logic [3:0]  heap_reg;
    logic [6:0]  offset_reg;
    logic [1:0]  status_reg;
    logic [11:0] recycled_reg;
    logic        last_reg;
    logic [10:0] out_page_next;
    logic [3:0]  heap_next;
    logic [6:0]  offset_next;
    logic [1:0]  status_next;
    logic [11:0] recycled_next;

    logic        out_free;
    logic [6:0]  count_sat;
    logic [MW-1:0] quo_full;
    logic [10:0] quo;
    logic [21:0] quo_scaled;
    logic [21:0] rem_full;
    logic [CW+3:0] chunk_heap_ext;
    logic [JW+6:0] chunk_off_ext;
    page_entry_t chunk_entry;
    page_entry_t pend_entry;
    logic        free_room;

    assign out_free  = !out_valid_reg || !out_stall;
    assign count_sat = (alloc_count > MAX_ALLOC) ? MAX_ALLOC : alloc_count;
    assign free_room = (free_fill_reg < FW'(POOL_PAGES));

    // Page split for a freed page: quotient by reciprocal, remainder by
    // subtracting the scaled quotient.
    assign quo        = quo_full[10:0];
    assign quo_full   = mul_reg >> SHIFT;
    assign quo_scaled = 22'(quo) * 22'(PAGES_PER_HEAP);
    assign rem_full   = 22'(page_in_reg) - quo_scaled;

    assign pend_entry.page   = page_in_reg;
    assign pend_entry.heap   = quo[HEAP_W-1:0];
    assign pend_entry.offset = rem_full[OFFSET_W-1:0];

    // Next page of a fresh chunk.
    assign chunk_heap_ext     = {{HEAP_W{1'b0}}, chunks_reg};
    assign chunk_off_ext      = {{OFFSET_W{1'b0}}, chunk_off_reg};
    assign chunk_entry.page   = chunk_page_reg;
    assign chunk_entry.heap   = chunk_heap_ext[HEAP_W-1:0];
    assign chunk_entry.offset = chunk_off_ext[OFFSET_W-1:0];

    // Status toward the controller.
    always_comb
    begin
        status.kind           = kind_reg;
        status.count_zero     = (count_reg == 7'd0);
        status.last_in        = last_in_reg;
        status.alloc_final    = (count_left_reg == 7'd1);
        status.free_empty     = (free_fill_reg == '0);
        status.pool_exhausted = (chunks_reg >= CW'(MAX_HEAPS));
        status.chunk_last     = (chunk_off_reg == JW'(PAGES_PER_HEAP - 1));
        status.pend_full      = (pend_count_reg >= FW'(POOL_PAGES));
        status.pend_empty     = (pend_count_reg == '0);
        status.batch_full     = (batch_fill_reg >= BFW'(PENDING_BATCHES));
        status.batch_empty    = (batch_fill_reg == '0);
        status.fence_ok       = (fence_rd_reg <= fence_in_reg);
        status.remain_zero    = (remain_reg == '0);
        status.out_free       = out_free;
    end

    // Input latch, product register and memory read data.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg     <= kind;
            count_reg    <= count_sat;
            page_in_reg  <= page_index;
            fence_in_reg <= fence_value;
            last_in_reg  <= batch_last;
        end
        mul_reg <= MW'(page_in_reg) * MW'(RECIP);
        if (cmd.alloc_pop)
        begin
            free_rd_reg <= free_mem[free_head_reg];
        end
        if (cmd.pend_rd)
        begin
            pend_rd_reg <= pend_mem[pend_head_reg];
        end
        if (cmd.batch_rd)
        begin
            fence_rd_reg <= fence_mem[batch_head_reg];
            size_rd_reg  <= size_mem[batch_head_reg];
        end
    end

    // Memory writes: the free queue takes chunk pages or recycled pages.
    always_ff @(posedge clk)
    begin
        if (cmd.chunk_push)
        begin
            free_mem[free_tail_reg] <= chunk_entry;
        end
        else if (cmd.recycle_push && free_room)
        begin
            free_mem[free_tail_reg] <= pend_rd_reg;
        end
        if (cmd.free_commit)
        begin
            pend_mem[pend_tail_reg] <= pend_entry;
            if (last_in_reg)
            begin
                fence_mem[batch_tail_reg] <= fence_in_reg;
                size_mem[batch_tail_reg]  <= open_size_reg + FW'(1);
            end
        end
    end

    // Free queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            free_tail_reg <= '0;
            free_fill_reg <= '0;
        end
        else
        begin
            if (cmd.chunk_push || (cmd.recycle_push && free_room))
            begin
                free_tail_reg <= (free_tail_reg == PAW'(POOL_PAGES - 1)) ?
                                 '0 : free_tail_reg + PAW'(1);
            end
            if (cmd.alloc_pop)
            begin
                free_head_reg <= (free_head_reg == PAW'(POOL_PAGES - 1)) ?
                                 '0 : free_head_reg + PAW'(1);
            end
            priority if (cmd.alloc_pop)
            begin
                free_fill_reg <= free_fill_reg - FW'(1);
            end
            else if (cmd.chunk_push || (cmd.recycle_push && free_room))
            begin
                free_fill_reg <= free_fill_reg + FW'(1);
            end
        end
    end

    // Chunk refill counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunks_reg     <= '0;
            chunk_off_reg  <= '0;
            chunk_page_reg <= '0;
        end
        else if (cmd.chunk_push)
        begin
            chunk_page_reg <= chunk_page_reg + 11'd1;
            if (chunk_off_reg == JW'(PAGES_PER_HEAP - 1))
            begin
                chunk_off_reg <= '0;
                chunks_reg    <= chunks_reg + CW'(1);
            end
            else
            begin
                chunk_off_reg <= chunk_off_reg + JW'(1);
            end
        end
    end

    // Pending queue, batch store pointers and recycle counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_head_reg  <= '0;
            pend_tail_reg  <= '0;
            pend_count_reg <= '0;
            batch_head_reg <= '0;
            batch_tail_reg <= '0;
            batch_fill_reg <= '0;
            open_size_reg  <= '0;
            remain_reg     <= '0;
            moved_reg      <= '0;
            count_left_reg <= '0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                count_left_reg <= count_sat;
            end
            else if (cmd.emit && (cmd.emit_sel == RES_PAGE))
            begin
                count_left_reg <= count_left_reg - 7'd1;
            end
            if (cmd.free_commit)
            begin
                pend_tail_reg  <= (pend_tail_reg == PAW'(POOL_PAGES - 1)) ?
                                  '0 : pend_tail_reg + PAW'(1);
                pend_count_reg <= pend_count_reg + FW'(1);
                if (last_in_reg)
                begin
                    batch_tail_reg <= (batch_tail_reg == BW'(PENDING_BATCHES - 1)) ?
                                      '0 : batch_tail_reg + BW'(1);
                    batch_fill_reg <= batch_fill_reg + BFW'(1);
                    open_size_reg  <= '0;
                end
                else
                begin
                    open_size_reg <= open_size_reg + FW'(1);
                end
            end
            if (cmd.pend_rd)
            begin
                pend_head_reg  <= (pend_head_reg == PAW'(POOL_PAGES - 1)) ?
                                  '0 : pend_head_reg + PAW'(1);
                pend_count_reg <= pend_count_reg - FW'(1);
                remain_reg     <= remain_reg - FW'(1);
            end
            else if (cmd.batch_load)
            begin
                remain_reg <= size_rd_reg;
            end
            if (cmd.batch_pop)
            begin
                batch_head_reg <= (batch_head_reg == BW'(PENDING_BATCHES - 1)) ?
                                  '0 : batch_head_reg + BW'(1);
                batch_fill_reg <= batch_fill_reg - BFW'(1);
            end
            if (cmd.moved_clr)
            begin
                moved_reg <= '0;
            end
            else if (cmd.recycle_push && free_room && (moved_reg != MOVED_MAX))
            begin
                moved_reg <= moved_reg + 12'd1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Fields of the result word selected for the output register.
    always_comb
    begin
        out_page_next = '0;
        heap_next     = '0;
        offset_next   = '0;
        status_next   = ST_OK;
        recycled_next = '0;
        unique case (cmd.emit_sel)
            RES_PAGE:
            begin
                out_page_next = free_rd_reg.page;
                heap_next     = free_rd_reg.heap;
                offset_next   = free_rd_reg.offset;
            end
            RES_EXHAUST:
            begin
                status_next = ST_EXHAUST;
            end
            RES_FULL:
            begin
                status_next = ST_FULL;
            end
            RES_RECYCLE:
            begin
                recycled_next = moved_reg;
            end
            RES_ZERO:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_page_reg <= out_page_next;
            heap_reg     <= heap_next;
            offset_reg   <= offset_next;
            status_reg   <= status_next;
            recycled_reg <= recycled_next;
            last_reg     <= cmd.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_page       = out_page_reg;
    assign heap_number    = heap_reg;
    assign heap_offset    = offset_reg;
    assign status_code    = status_reg;
    assign pages_recycled = recycled_reg;
    assign last_result    = last_reg;

`ifndef NO_ASSERTIONS
    // The free queue never holds more pages than the pool.
    a_free_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_fill_reg <= FW'(POOL_PAGES))
        else $error("free queue fill beyond pool size");

    // The batch store never holds more batches than its depth.
    a_batch_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        batch_fill_reg <= BFW'(PENDING_BATCHES))
        else $error("batch store fill beyond depth");

    // A result word is loaded only when the output register can take it.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result word overwritten before it was taken");

    // Pages are popped only from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.alloc_pop || (free_fill_reg != '0)) &&
        (!cmd.pend_rd || (pend_count_reg != '0)))
        else $error("pop from an empty page queue");

    // The open batch is always backed by pages still pending.
    a_open_backed: assert property (@(posedge clk) disable iff (!rst_n)
        open_size_reg <= pend_count_reg)
        else $error("open batch larger than pending queue");
`endif

endmodule

@@ hdl/fenced_page_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fenced_page_pool_allocator_unit: page pool with fence-gated recycling
// Allocates pages from a free queue refilled chunk by chunk, queues freed
// pages into fenced batches and returns completed batches to the pool.
// ----------------------------------------------------------------------------
//
//  channel   handshake            word fields
//  input     in_valid / in_stall  kind, alloc_count, page_index, fence_value,
//                                 batch_last
//  output    out_valid/out_stall  out_page, heap_number, heap_offset, status,
//                                 pages_recycled, last_result
//
//  Free queues the split page as pending; unknown kind, zero count or refused free emit one result.
//  Allocate emits page by page, refilling an empty free queue by a chunk or reporting an empty pool.
//  Recycle moves batches page by page to the free queue until a fence stops it.
//  Each result waits in place while the output register holds a word not yet taken.
//  Reset clears all queue pointers and counts at once; no clearing pass runs.
//
module fenced_page_pool_allocator_unit #(
    parameter int PAGES_PER_HEAP  = 128,
    parameter int MAX_HEAPS       = 16,
    parameter int PENDING_BATCHES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [6:0]  alloc_count,
    input  logic [10:0] page_index,
    input  logic [31:0] fence_value,
    input  logic        batch_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] out_page,
    output logic [3:0]  heap_number,
    output logic [6:0]  heap_offset,
    output logic [1:0]  status,
    output logic [11:0] pages_recycled,
    output logic        last_result
);
    import fppa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_status;
    kind_t      kind_in;

    assign kind_in = kind_t'(kind);

    // Sequencing controller.
    fppa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // Queues, batch store and output register.
    fppa_dpath #(
        .PAGES_PER_HEAP  (PAGES_PER_HEAP),
        .MAX_HEAPS       (MAX_HEAPS),
        .PENDING_BATCHES (PENDING_BATCHES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (dp_status),
        .kind           (kind_in),
        .alloc_count    (alloc_count),
        .page_index     (page_index),
        .fence_value    (fence_value),
        .batch_last     (batch_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_page       (out_page),
        .heap_number    (heap_number),
        .heap_offset    (heap_offset),
        .status_code    (status),
        .pages_recycled (pages_recycled),
        .last_result    (last_result)
    );

endmodule
